[src/wrbg_pkg.sv]
// ----------------------------------------------------------------------------
// wrbg_pkg: shared definitions for the waypoint guidance unit
// Widths, register indexes, reset values, the CORDIC arctangent table and the
// side-band word that travels alongside the arithmetic pipelines.
// ----------------------------------------------------------------------------
package wrbg_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_MAX_STAGES = 32;

  // The square root yields one result bit per stage; both long pipelines share
  // this depth so that their results line up.
  localparam int ISQRT_STAGES = 32;

  // CORDIC vector width (delta times 256 plus gain headroom) and angle width
  // (degrees scaled by 2^24).
  localparam int CW = 43;
  localparam int ZW = 34;

  localparam logic [1:0] CFG_CRUISE_DISTANCE = 2'd0;
  localparam logic [1:0] CFG_FULL_SPEED      = 2'd1;
  localparam logic [1:0] CFG_SLOW_RATIO      = 2'd2;

  localparam logic [31:0] CRUISE_DISTANCE_RST = 32'd65536;
  localparam logic [15:0] FULL_SPEED_RST      = 16'd1000;
  localparam logic [8:0]  SLOW_RATIO_RST      = 9'd128;

  localparam logic signed [ZW-1:0] Z_QUARTER   = 34'sd1509949440;
  localparam logic signed [16:0]   BRG_HALF    = 17'sd46080;
  localparam logic signed [16:0]   BRG_QUARTER = 17'sd23040;
  localparam logic signed [32:0]   RANGE_OFF   = -33'sd65536;

  localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_MAX_STAGES] = '{
    34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
    34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
    34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
    34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
    34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
    34'sd917,       34'sd458,       34'sd229,       34'sd115,
    34'sd57,        34'sd29,        34'sd14,        34'sd7,
    34'sd4,         34'sd2,         34'sd1,         34'sd0
  };

  typedef struct packed {
    logic               en;
    logic               ovr;
    logic signed [16:0] ovr_brg;
    logic signed [16:0] yaw;
    logic signed [30:0] tx;
    logic signed [30:0] ty;
  } side_t;

endpackage

[src/wrbg_isqrt.sv]
// ----------------------------------------------------------------------------
// wrbg_isqrt: pipelined integer square root
// Restoring digit-by-digit root of a 64-bit value, one result bit per stage.
// Gives the floor root and the remainder for the rounding stage downstream.
// ----------------------------------------------------------------------------
module wrbg_isqrt (
  input  logic        clk,
  input  logic        adv,
  input  logic [63:0] n_i,
  output logic [31:0] root_o,
  output logic [33:0] rem_o
);

  localparam int DEPTH = wrbg_pkg::ISQRT_STAGES;

  logic [63:0] n_in    [DEPTH];
  logic [31:0] root_in [DEPTH];
  logic [33:0] rem_in  [DEPTH];
  logic [63:0] n_out    [DEPTH-1];
  logic [31:0] root_out [DEPTH];
  logic [33:0] rem_out  [DEPTH];

  assign n_in[0]    = n_i;
  assign root_in[0] = '0;
  assign rem_in[0]  = '0;

  for (genvar k = 1; k < DEPTH; k++) begin : g_link
    assign n_in[k]    = n_out[k-1];
    assign root_in[k] = root_out[k-1];
    assign rem_in[k]  = rem_out[k-1];
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        take;
    logic [31:0] root_r;
    logic [33:0] rem_r;

    assign rem_sh = {rem_in[k], n_in[k][63:62]};
    assign trial  = {2'b00, root_in[k], 2'b01};
    assign take   = (rem_sh >= trial);

    // The remainder never exceeds twice the new root, so 34 bits hold it.
    always_ff @(posedge clk) begin
      if (adv) begin
        if (take) begin
          rem_r  <= 34'(rem_sh - trial);
          root_r <= {root_in[k][30:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[33:0];
          root_r <= {root_in[k][30:0], 1'b0};
        end
      end
    end

    assign root_out[k] = root_r;
    assign rem_out[k]  = rem_r;

    if (k < DEPTH-1) begin : g_n
      logic [63:0] n_r;
      always_ff @(posedge clk) begin
        if (adv) begin
          n_r <= {n_in[k][61:0], 2'b00};
        end
      end
      assign n_out[k] = n_r;
    end
  end

  assign root_o = root_out[DEPTH-1];
  assign rem_o  = rem_out[DEPTH-1];

endmodule

[src/wrbg_cordic.sv]
// ----------------------------------------------------------------------------
// wrbg_cordic: pipelined CORDIC vectoring unit
// Drives the vector onto the positive x axis, one micro-rotation per stage,
// and accumulates the angle in degrees scaled by 2^24. Stages beyond the
// configured iteration count pass their word through unchanged.
// ----------------------------------------------------------------------------
module wrbg_cordic #(
  parameter int STAGES = wrbg_pkg::CORDIC_STAGES_DEF
) (
  input  logic                           clk,
  input  logic                           adv,
  input  logic signed [wrbg_pkg::CW-1:0] x_i,
  input  logic signed [wrbg_pkg::CW-1:0] y_i,
  input  logic signed [wrbg_pkg::ZW-1:0] z_i,
  output logic signed [wrbg_pkg::ZW-1:0] z_o
);

  localparam int DEPTH = wrbg_pkg::ISQRT_STAGES;
  localparam int CW    = wrbg_pkg::CW;
  localparam int ZW    = wrbg_pkg::ZW;

  logic signed [CW-1:0] x_in  [DEPTH];
  logic signed [CW-1:0] y_in  [DEPTH];
  logic signed [ZW-1:0] z_in  [DEPTH];
  logic signed [CW-1:0] x_out [DEPTH-1];
  logic signed [CW-1:0] y_out [DEPTH-1];
  logic signed [ZW-1:0] z_out [DEPTH];

  assign x_in[0] = x_i;
  assign y_in[0] = y_i;
  assign z_in[0] = z_i;

  for (genvar k = 1; k < DEPTH; k++) begin : g_link
    assign x_in[k] = x_out[k-1];
    assign y_in[k] = y_out[k-1];
    assign z_in[k] = z_out[k-1];
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_stage
    localparam bit ROT = (k < STAGES);
    logic                 pos;
    logic signed [ZW-1:0] z_r;

    assign pos = !y_in[k][CW-1] && (y_in[k] != '0);

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!ROT) begin
          z_r <= z_in[k];
        end else if (pos) begin
          z_r <= z_in[k] + wrbg_pkg::ATAN_TAB[k];
        end else begin
          z_r <= z_in[k] - wrbg_pkg::ATAN_TAB[k];
        end
      end
    end

    assign z_out[k] = z_r;

    // The last stage only needs the sign of y, so it keeps no vector.
    if (k < DEPTH-1) begin : g_xy
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      logic signed [CW-1:0] x_r;
      logic signed [CW-1:0] y_r;

      assign xs = x_in[k] >>> k;
      assign ys = y_in[k] >>> k;

      always_ff @(posedge clk) begin
        if (adv) begin
          if (!ROT) begin
            x_r <= x_in[k];
            y_r <= y_in[k];
          end else if (pos) begin
            x_r <= x_in[k] + ys;
            y_r <= y_in[k] - xs;
          end else begin
            x_r <= x_in[k] - ys;
            y_r <= y_in[k] + xs;
          end
        end
      end

      assign x_out[k] = x_r;
      assign y_out[k] = y_r;
    end
  end

  assign z_o = z_out[DEPTH-1];

endmodule

[src/waypoint_range_bearing_guidance_unit.sv]
// ----------------------------------------------------------------------------
// waypoint_range_bearing_guidance_unit: range, bearing and speed guidance
// One pose sample in, one guidance word out: range, bearing, heading error,
// speed command and target echo.
// ----------------------------------------------------------------------------
// The unit takes one sample word every clock cycle while it is not stalled and
// returns its guidance word through three front stages (position delta,
// squares, sum and CORDIC pre-rotation), a 32-stage square-root pipeline
// producing one range bit per stage with the CORDIC bearing pipeline running
// beside it, then a rounding stage and the output register.
// While the output word is held by out_stall the whole pipeline stops and
// in_stall is raised; nothing is lost or repeated. Configuration writes take
// effect at once and should be made while no word is in flight.
// ----------------------------------------------------------------------------
module waypoint_range_bearing_guidance_unit #(
  parameter int CORDIC_STAGES = wrbg_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_running,
  input  logic               in_target_valid,
  input  logic signed [30:0] in_target_x,
  input  logic signed [30:0] in_target_y,
  input  logic signed [30:0] in_current_x,
  input  logic signed [30:0] in_current_y,
  input  logic signed [16:0] in_current_yaw,

  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_motion_en,
  output logic signed [32:0] out_range_to_target,
  output logic signed [16:0] out_bearing_to_target,
  output logic signed [16:0] out_heading_error,
  output logic [15:0]        out_speed_command,
  output logic signed [30:0] out_target_x_echo,
  output logic signed [30:0] out_target_y_echo
);

  localparam int DEPTH = wrbg_pkg::ISQRT_STAGES;
  localparam int CW    = wrbg_pkg::CW;
  localparam int ZW    = wrbg_pkg::ZW;

  // Configuration registers
  logic [31:0] cruise_distance_r;
  logic [15:0] full_speed_r;
  logic [8:0]  slow_ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cruise_distance_r <= wrbg_pkg::CRUISE_DISTANCE_RST;
      full_speed_r      <= wrbg_pkg::FULL_SPEED_RST;
      slow_ratio_r      <= wrbg_pkg::SLOW_RATIO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wrbg_pkg::CFG_CRUISE_DISTANCE: cruise_distance_r <= cfg_wdata;
        wrbg_pkg::CFG_FULL_SPEED:      full_speed_r      <= cfg_wdata[15:0];
        wrbg_pkg::CFG_SLOW_RATIO:      slow_ratio_r      <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one; it halts only while the output word is held.
  logic adv;
  logic out_valid_r;

  assign in_stall = out_valid_r && out_stall;
  assign adv      = !in_stall;

  // Stage A: position delta
  logic                 vld_a_r;
  wrbg_pkg::side_t      side_a_r;
  wrbg_pkg::side_t      side_a_nxt;
  logic signed [31:0]   dx_a_r;
  logic signed [31:0]   dy_a_r;

  always_comb begin
    side_a_nxt         = '0;
    side_a_nxt.en      = in_running && in_target_valid;
    side_a_nxt.yaw     = in_current_yaw;
    side_a_nxt.tx      = in_target_x;
    side_a_nxt.ty      = in_target_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (adv) begin
      vld_a_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_a_r <= side_a_nxt;
      dx_a_r   <= 32'(in_target_x) - 32'(in_current_x);
      dy_a_r   <= 32'(in_target_y) - 32'(in_current_y);
    end
  end

  // Stage B: squares and the axis-aligned bearing cases
  logic                 vld_b_r;
  wrbg_pkg::side_t      side_b_r;
  wrbg_pkg::side_t      side_b_nxt;
  logic signed [31:0]   dx_b_r;
  logic signed [31:0]   dy_b_r;
  logic [31:0]          adx_nxt;
  logic [31:0]          ady_nxt;
  logic [63:0]          sqx_b_r;
  logic [63:0]          sqy_b_r;
  logic                 dx_zero;
  logic                 dy_zero;

  assign adx_nxt = dx_a_r[31] ? 32'(-dx_a_r) : 32'(dx_a_r);
  assign ady_nxt = dy_a_r[31] ? 32'(-dy_a_r) : 32'(dy_a_r);
  assign dx_zero = (dx_a_r == '0);
  assign dy_zero = (dy_a_r == '0);

  always_comb begin
    side_b_nxt         = side_a_r;
    side_b_nxt.ovr     = dx_zero || dy_zero;
    side_b_nxt.ovr_brg = '0;
    if (dx_zero && dy_zero) begin
      side_b_nxt.ovr_brg = '0;
    end else if (dy_zero) begin
      side_b_nxt.ovr_brg = dx_a_r[31] ? wrbg_pkg::BRG_HALF : 17'sd0;
    end else if (dx_zero) begin
      side_b_nxt.ovr_brg = dy_a_r[31] ? -wrbg_pkg::BRG_QUARTER : wrbg_pkg::BRG_QUARTER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (adv) begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_b_r <= side_b_nxt;
      dx_b_r   <= dx_a_r;
      dy_b_r   <= dy_a_r;
      sqx_b_r  <= 64'(adx_nxt) * 64'(adx_nxt);
      sqy_b_r  <= 64'(ady_nxt) * 64'(ady_nxt);
    end
  end

  // Stage C: sum of squares and quadrant pre-rotation into the right half plane
  logic                 vld_c_r;
  wrbg_pkg::side_t      side_c_r;
  logic [63:0]          sum_c_r;
  logic signed [CW-1:0] xw;
  logic signed [CW-1:0] yw;
  logic signed [CW-1:0] x_nxt;
  logic signed [CW-1:0] y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic signed [CW-1:0] x_c_r;
  logic signed [CW-1:0] y_c_r;
  logic signed [ZW-1:0] z_c_r;

  assign xw = {{3{dx_b_r[31]}}, dx_b_r, 8'b0};
  assign yw = {{3{dy_b_r[31]}}, dy_b_r, 8'b0};

  always_comb begin
    x_nxt = xw;
    y_nxt = yw;
    z_nxt = '0;
    if (xw[CW-1]) begin
      if (!yw[CW-1]) begin
        x_nxt = yw;
        y_nxt = -xw;
        z_nxt = wrbg_pkg::Z_QUARTER;
      end else begin
        x_nxt = -yw;
        y_nxt = xw;
        z_nxt = -wrbg_pkg::Z_QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else if (adv) begin
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_c_r <= side_b_r;
      sum_c_r  <= sqx_b_r + sqy_b_r;
      x_c_r    <= x_nxt;
      y_c_r    <= y_nxt;
      z_c_r    <= z_nxt;
    end
  end

  // Stage D: square root and CORDIC, side-band delayed alongside
  logic [DEPTH-1:0]     vld_d_r;
  wrbg_pkg::side_t      side_d_r [DEPTH];
  logic [31:0]          root_d;
  logic [33:0]          rem_d;
  logic signed [ZW-1:0] z_d;

  wrbg_isqrt u_isqrt (
    .clk    (clk),
    .adv    (adv),
    .n_i    (sum_c_r),
    .root_o (root_d),
    .rem_o  (rem_d)
  );

  wrbg_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk (clk),
    .adv (adv),
    .x_i (x_c_r),
    .y_i (y_c_r),
    .z_i (z_c_r),
    .z_o (z_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= '0;
    end else if (adv) begin
      vld_d_r <= {vld_d_r[DEPTH-2:0], vld_c_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d_r[0] <= side_c_r;
      for (int i = 1; i < DEPTH; i++) begin
        side_d_r[i] <= side_d_r[i-1];
      end
    end
  end

  // Stage E: round the range, round and clamp the bearing, scale the slow speed
  logic                 vld_e_r;
  wrbg_pkg::side_t      side_e_r;
  logic [32:0]          rng_e_r;
  logic signed [16:0]   brg_e_r;
  logic [15:0]          slow_e_r;
  logic [32:0]          rng_nxt;
  logic signed [ZW:0]   z_rnd;
  logic signed [18:0]   q_full;
  logic signed [16:0]   brg_nxt;
  logic [24:0]          slow_prod;
  logic [25:0]          slow_sum;
  logic [15:0]          slow_nxt;

  // The remainder is n - root^2, so rounding to nearest needs no square.
  assign rng_nxt = {1'b0, root_d} + 33'(rem_d > {2'b00, root_d});

  assign z_rnd  = {z_d[ZW-1], z_d} + 35'sd32768;
  assign q_full = z_rnd[ZW:16];

  always_comb begin
    if (side_d_r[DEPTH-1].ovr) begin
      brg_nxt = side_d_r[DEPTH-1].ovr_brg;
    end else if (q_full > 19'sd46080) begin
      brg_nxt = wrbg_pkg::BRG_HALF;
    end else if (q_full < -19'sd46080) begin
      brg_nxt = -wrbg_pkg::BRG_HALF;
    end else begin
      brg_nxt = q_full[16:0];
    end
  end

  assign slow_prod = 25'(full_speed_r) * 25'(slow_ratio_r);
  assign slow_sum  = 26'(slow_prod) + 26'd128;
  assign slow_nxt  = (slow_sum[25:24] != 2'b00) ? 16'hFFFF : slow_sum[23:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_e_r <= 1'b0;
    end else if (adv) begin
      vld_e_r <= vld_d_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_e_r <= side_d_r[DEPTH-1];
      rng_e_r  <= rng_nxt;
      brg_e_r  <= brg_nxt;
      slow_e_r <= slow_nxt;
    end
  end

  // Output stage: heading error wrap, speed choice and the disabled word
  logic signed [18:0] err_diff;
  logic signed [18:0] err_wrap;
  logic [15:0]        spd_nxt;
  logic               en_e;

  assign en_e     = side_e_r.en;
  assign err_diff = 19'(brg_e_r) - 19'(side_e_r.yaw);

  always_comb begin
    if (err_diff > 19'sd46080) begin
      err_wrap = err_diff - 19'sd92160;
    end else if (err_diff <= -19'sd46080) begin
      err_wrap = err_diff + 19'sd92160;
    end else begin
      err_wrap = err_diff;
    end
  end

  assign spd_nxt = (rng_e_r > {1'b0, cruise_distance_r}) ? full_speed_r : slow_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_motion_en         <= en_e;
      out_range_to_target   <= en_e ? $signed(rng_e_r) : wrbg_pkg::RANGE_OFF;
      out_bearing_to_target <= en_e ? brg_e_r : 17'sd0;
      out_heading_error     <= en_e ? err_wrap[16:0] : 17'sd0;
      out_speed_command     <= en_e ? spd_nxt : 16'd0;
      out_target_x_echo     <= en_e ? side_e_r.tx : 31'sd0;
      out_target_y_echo     <= en_e ? side_e_r.ty : 31'sd0;
    end
  end

  assign out_valid = out_valid_r;

endmodule
